/* rtl/srbl_pkg.sv */
// Shared types and constants for the sliced ring buffer with slice locks.
// Used by the channel interfaces, the top level and the testbench.
// Depends on nothing.
package srbl_pkg;

  // Field widths of the transfer channels.
  localparam int OP_W        = 3;
  localparam int BYTE_W      = 8;
  localparam int SLICE_ID_W  = 4;
  localparam int OFFSET_W    = 10;
  localparam int STATUS_W    = 2;

  // Configuration registers and their port.
  localparam int SIZE_REG_W  = 11;
  localparam int COUNT_REG_W = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;
  localparam logic [SIZE_REG_W-1:0]  SIZE_AT_RESET  = SIZE_REG_W'(256);
  localparam logic [COUNT_REG_W-1:0] COUNT_AT_RESET = COUNT_REG_W'(4);
  localparam int SIZE_REG_MAX  = (1 << SIZE_REG_W) - 1;
  localparam int COUNT_REG_MAX = (1 << COUNT_REG_W) - 1;
  localparam int COUNT_MIN     = 3;

  // Default sizing of the ring.
  localparam int MAX_SLICES_DEF      = 16;
  localparam int MAX_SLICE_BYTES_DEF = 1024;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SLICE_SIZE  = 2'd0,
    REG_SLICE_COUNT = 2'd1
  } reg_index_t;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_WRITE      = 3'd0,
    OP_FETCH      = 3'd1,
    OP_UNLOCK_ID  = 3'd2,
    OP_UNLOCK_CUR = 3'd3,
    OP_READ       = 3'd4
  } op_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE   = 2'd0,
    STAT_LOCKED = 2'd1,
    STAT_RANGE  = 2'd2
  } status_t;

  // Control states of the top level.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_RDWAIT
  } state_t;

endpackage

/* rtl/srbl_req_if.sv */
// Request channel of the sliced ring buffer: valid, ready and one input item.
// Depends on srbl_pkg for the field widths.
interface srbl_req_if;
  import srbl_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       operation;
  logic [BYTE_W-1:0]     data_byte;
  logic                  last_of_block;
  logic [SLICE_ID_W-1:0] slice_id;
  logic [OFFSET_W-1:0]   byte_offset;

  modport source (output valid, operation, data_byte, last_of_block, slice_id, byte_offset,
                  input ready);
  modport sink   (input valid, operation, data_byte, last_of_block, slice_id, byte_offset,
                  output ready);
endinterface

/* rtl/srbl_rsp_if.sv */
// Response channel of the sliced ring buffer: valid, ready and one result item.
// Depends on srbl_pkg for the field widths.
interface srbl_rsp_if;
  import srbl_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [BYTE_W-1:0]     read_byte;
  logic [SLICE_ID_W-1:0] fetched_slice;
  logic [SLICE_ID_W-1:0] write_slice_now;

  modport source (output valid, status, read_byte, fetched_slice, write_slice_now,
                  input ready);
  modport sink   (input valid, status, read_byte, fetched_slice, write_slice_now,
                  output ready);
endinterface

/* rtl/srbl_cfg_if.sv */
// Configuration write channel: valid, ready, register index and write data.
// Depends on srbl_pkg for the field widths.
interface srbl_cfg_if;
  import srbl_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/srbl_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module srbl_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read port with the data registered.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/sliced_ring_buffer_with_locks_unit.sv */
// Top level of the sliced ring buffer with slice locks: pointers, locks and control.
// Depends on srbl_pkg, the three channel interfaces and srbl_ram for the byte store.
//
// A byte store split into slice_count slices of slice_size bytes. Writes, fetches and
// unlocks are decided in the cycle they are accepted and their result is in the output
// register at the next edge, so such items can follow one another every cycle while the
// output register is free. An in-range byte read goes through the registered read port
// of the store RAM, and no further item is accepted while it is outstanding. After reset
// the store is cleared to zero, one byte per cycle, before the first item is accepted;
// configuration writes are taken throughout. A configuration write to either register
// keeps the store contents but returns the pointers and all locks to zero. Out-of-range
// register values are clamped when used.
module sliced_ring_buffer_with_locks_unit #(
  parameter int MAX_SLICES      = srbl_pkg::MAX_SLICES_DEF,
  parameter int MAX_SLICE_BYTES = srbl_pkg::MAX_SLICE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  srbl_req_if.sink   req,
  srbl_rsp_if.source rsp,
  srbl_cfg_if.sink   cfg
);
  import srbl_pkg::*;

  // Largest sizes reachable by the clamped registers.
  localparam int SIZE_CAP  = (MAX_SLICE_BYTES < SIZE_REG_MAX) ? MAX_SLICE_BYTES : SIZE_REG_MAX;
  localparam int COUNT_CAP = (MAX_SLICES < COUNT_REG_MAX) ? MAX_SLICES : COUNT_REG_MAX;
  localparam int OW        = (SIZE_CAP > 1) ? $clog2(SIZE_CAP) : 1;
  localparam int SZW       = $clog2(SIZE_CAP + 1);
  localparam int OSW       = SZW + 1;
  localparam int SW        = $clog2(COUNT_CAP);
  localparam int CW        = $clog2(COUNT_CAP + 1);
  localparam int DEPTH     = MAX_SLICES * MAX_SLICE_BYTES;
  localparam int AW        = $clog2(DEPTH);

  state_t state;
  state_t state_next;

  logic [SIZE_REG_W-1:0]  slice_size;
  logic [COUNT_REG_W-1:0] slice_count;
  logic [SZW-1:0]         eff_size;
  logic [CW-1:0]          eff_count;

  logic [SW-1:0]          write_slice;
  logic [SW-1:0]          write_slice_next;
  logic [OW-1:0]          write_offset;
  logic [OW-1:0]          write_offset_next;
  logic [AW-1:0]          write_base;
  logic [AW-1:0]          write_base_next;
  logic [SW-1:0]          read_slice;
  logic [SW-1:0]          read_slice_next;
  logic                   within_block;
  logic                   within_block_next;
  logic [COUNT_CAP-1:0]   locks;
  logic [COUNT_CAP-1:0]   locks_next;
  logic [AW-1:0]          clr_addr;

  logic                   out_valid;
  status_t                out_status;
  logic [BYTE_W-1:0]      out_byte;
  logic [SLICE_ID_W-1:0]  out_fetched;
  logic [SLICE_ID_W-1:0]  out_write;

  op_t                    op;
  status_t                status_c;
  logic                   req_fire;
  logic                   cfg_fire;
  logic                   rsp_free;
  logic                   wr_refused;
  logic                   sid_ok;
  logic                   off_ok;
  logic                   off_full;
  logic                   ws_wrap;
  logic                   rs_wrap;
  logic [SW-1:0]          sid_idx;
  logic [SW+SZW-1:0]      rd_prod;
  logic [AW-1:0]          wr_addr;
  logic [AW-1:0]          rd_addr;
  logic                   load_rsp;
  logic                   load_from_mem;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [BYTE_W-1:0]      mem_wdata;
  logic                   mem_re;
  logic [BYTE_W-1:0]      mem_rdata;

  // Handshakes.
  assign op       = op_t'(req.operation);
  assign rsp_free = !out_valid || rsp.ready;
  assign req.ready = (state == ST_RUN) && rsp_free;
  assign req_fire = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign cfg_fire = cfg.valid;

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.read_byte       = out_byte;
  assign rsp.fetched_slice   = out_fetched;
  assign rsp.write_slice_now = out_write;

  // Clamp the register values to the sizes the ring supports.
  always_comb begin
    priority if (slice_size == '0) begin
      eff_size = SZW'(1);
    end else if (int'(slice_size) > SIZE_CAP) begin
      eff_size = SZW'(SIZE_CAP);
    end else begin
      eff_size = SZW'(slice_size);
    end
    priority if (int'(slice_count) < COUNT_MIN) begin
      eff_count = CW'(COUNT_MIN);
    end else if (int'(slice_count) > COUNT_CAP) begin
      eff_count = CW'(COUNT_CAP);
    end else begin
      eff_count = CW'(slice_count);
    end
  end

  // Range checks, pointer wrap conditions and store addresses.
  assign sid_ok   = int'(req.slice_id) < int'(eff_count);
  assign off_ok   = int'(req.byte_offset) < int'(eff_size);
  assign sid_idx  = SW'(req.slice_id);
  assign off_full = (OSW'(write_offset) + OSW'(1)) == OSW'(eff_size);
  assign ws_wrap  = (CW'(write_slice) + CW'(1)) == eff_count;
  assign rs_wrap  = (CW'(read_slice) + CW'(1)) == eff_count;
  assign wr_addr  = write_base + AW'(write_offset);
  assign rd_prod  = sid_idx * eff_size;
  assign rd_addr  = AW'(rd_prod) + AW'(req.byte_offset);

  // Pointer and lock updates for the item on the request channel.
  always_comb begin
    write_slice_next  = write_slice;
    write_offset_next = write_offset;
    write_base_next   = write_base;
    read_slice_next   = read_slice;
    within_block_next = within_block;
    locks_next        = locks;
    status_c          = STAT_DONE;
    wr_refused        = 1'b0;
    unique case (op)
      OP_WRITE: begin
        // The lock is checked at the first byte of a call and at the start of a slice.
        if ((!within_block || write_offset == '0) && locks[write_slice]) begin
          status_c   = STAT_LOCKED;
          wr_refused = 1'b1;
        end else begin
          if (off_full) begin
            write_offset_next = '0;
            if (ws_wrap) begin
              write_slice_next = '0;
              write_base_next  = '0;
            end else begin
              write_slice_next = write_slice + SW'(1);
              write_base_next  = write_base + AW'(eff_size);
            end
          end else begin
            write_offset_next = write_offset + OW'(1);
          end
          within_block_next = !req.last_of_block;
        end
      end
      OP_FETCH: begin
        read_slice_next             = rs_wrap ? '0 : read_slice + SW'(1);
        locks_next[read_slice_next] = 1'b1;
      end
      OP_UNLOCK_ID: begin
        if (!sid_ok) begin
          status_c = STAT_RANGE;
        end else begin
          locks_next[sid_idx] = 1'b0;
        end
      end
      OP_UNLOCK_CUR: begin
        locks_next[read_slice] = 1'b0;
      end
      OP_READ: begin
        if (!(sid_ok && off_ok)) begin
          status_c = STAT_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and store port control.
  always_comb begin
    state_next    = state;
    load_rsp      = 1'b0;
    load_from_mem = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = wr_addr;
    mem_wdata     = req.data_byte;
    mem_re        = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (req_fire) begin
          if (op == OP_READ && status_c == STAT_DONE) begin
            mem_re     = 1'b1;
            state_next = ST_RDWAIT;
          end else begin
            load_rsp = 1'b1;
          end
          if (op == OP_WRITE && !wr_refused) begin
            mem_we = 1'b1;
          end
        end
      end
      ST_RDWAIT: begin
        load_rsp      = 1'b1;
        load_from_mem = 1'b1;
        state_next    = ST_RUN;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Configuration, pointers, locks, clearing counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      slice_size   <= SIZE_AT_RESET;
      slice_count  <= COUNT_AT_RESET;
      write_slice  <= '0;
      write_offset <= '0;
      write_base   <= '0;
      read_slice   <= '0;
      within_block <= 1'b0;
      locks        <= '0;
      clr_addr     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (load_rsp) begin
        out_valid <= 1'b1;
      end
      if (cfg_fire && (cfg.index == REG_SLICE_SIZE || cfg.index == REG_SLICE_COUNT)) begin
        if (cfg.index == REG_SLICE_SIZE) begin
          slice_size <= SIZE_REG_W'(cfg.data);
        end else begin
          slice_count <= COUNT_REG_W'(cfg.data);
        end
        write_slice  <= '0;
        write_offset <= '0;
        write_base   <= '0;
        read_slice   <= '0;
        within_block <= 1'b0;
        locks        <= '0;
      end else if (req_fire) begin
        write_slice  <= write_slice_next;
        write_offset <= write_offset_next;
        write_base   <= write_base_next;
        read_slice   <= read_slice_next;
        within_block <= within_block_next;
        locks        <= locks_next;
      end
    end
  end

  // Result payload, from the decision logic or from the store read.
  always_ff @(posedge clk) begin
    if (load_rsp) begin
      if (load_from_mem) begin
        out_status  <= STAT_DONE;
        out_byte    <= mem_rdata;
        out_fetched <= SLICE_ID_W'(read_slice);
        out_write   <= SLICE_ID_W'(write_slice);
      end else begin
        out_status  <= status_c;
        out_byte    <= '0;
        out_fetched <= SLICE_ID_W'(read_slice_next);
        out_write   <= SLICE_ID_W'(write_slice_next);
      end
    end
  end

  // Byte store.
  srbl_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (rd_addr),
    .rd_data (mem_rdata)
  );

`ifndef SYNTHESIS
  // No item is taken while the store is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !req.ready)
    else $error("request accepted during the clearing pass");

  // While a store read is outstanding the output register is empty.
  a_rdwait_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RDWAIT) |-> !out_valid)
    else $error("output register full while a store read is outstanding");

  // An accepted in-range read moves to ST_RDWAIT to wait for the store.
  a_read_waits: assert property (@(posedge clk) disable iff (rst)
    (req_fire && op == OP_READ && status_c == STAT_DONE) |=> (state == ST_RDWAIT))
    else $error("in-range read did not wait for the store");

  // The write pointer stays inside the ring.
  a_write_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (int'(write_offset) < int'(eff_size)) && (int'(write_slice) < int'(eff_count)))
    else $error("write pointer outside the ring");
`endif

endmodule

/* tb/srbl_ring_checker.sv */
// Checker for the sliced ring buffer: watches the request, response and configuration
// channels, predicts every result from its own copy of the ring and compares them.
// Depends on srbl_pkg and the three channel interfaces.
module srbl_ring_checker (
  input  logic clk,
  input  logic rst,
  srbl_req_if  req,
  srbl_rsp_if  rsp,
  srbl_cfg_if  cfg,
  output int   failures,
  output int   results_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import srbl_pkg::*;

  localparam int STORE_DEPTH = MAX_SLICES_DEF * MAX_SLICE_BYTES_DEF;

  typedef struct packed {
    status_t               status;
    logic [BYTE_W-1:0]     read_byte;
    logic [SLICE_ID_W-1:0] fetched_slice;
    logic [SLICE_ID_W-1:0] write_slice_now;
  } ring_result_t;

  // Predicted contents and pointers of the ring.
  logic [BYTE_W-1:0]      store_copy [STORE_DEPTH];
  logic                   lock_bits  [MAX_SLICES_DEF];
  logic [SIZE_REG_W-1:0]  size_reg;
  logic [COUNT_REG_W-1:0] count_reg;
  int                     wr_slice;
  int                     wr_off;
  int                     rd_slice;
  bit                     in_call;

  ring_result_t pending_results [$];

  initial begin
    failures     = 0;
    results_owed = 0;
  end

  // Pointers and locks go back to zero on reset and on every write to either register.
  function automatic void restart_ring();
    for (int s = 0; s < MAX_SLICES_DEF; s++) lock_bits[s] = 1'b0;
    wr_slice = 0;
    wr_off   = 0;
    rd_slice = 0;
    in_call  = 1'b0;
  endfunction

  // Register values are clamped to the legal range when they are used.
  function automatic int slice_bytes();
    if (size_reg < 1) return 1;
    if (size_reg > MAX_SLICE_BYTES_DEF) return MAX_SLICE_BYTES_DEF;
    return int'(size_reg);
  endfunction

  function automatic int ring_slices();
    if (count_reg < COUNT_MIN) return COUNT_MIN;
    if (count_reg > MAX_SLICES_DEF) return MAX_SLICES_DEF;
    return int'(count_reg);
  endfunction

  // Applies one accepted item to the ring copy and returns the result it causes.
  function automatic ring_result_t advance_ring(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                                                logic last, logic [SLICE_ID_W-1:0] sid,
                                                logic [OFFSET_W-1:0] off);
    ring_result_t res;
    int           bytes;
    int           slices;
    bit           check_lock;
    bytes  = slice_bytes();
    slices = ring_slices();
    res    = '0;
    res.status = STAT_DONE;
    if (wr_slice >= slices) wr_slice = 0;
    if (wr_off >= bytes) wr_off = 0;
    if (rd_slice >= slices) rd_slice = 0;
    case (op)
      OP_WRITE: begin
        // The lock is only looked at on the first byte of a call or at a fresh slice.
        check_lock = !in_call || (wr_off == 0);
        if (check_lock && lock_bits[wr_slice]) begin
          res.status = STAT_LOCKED;
        end else begin
          store_copy[wr_slice * bytes + wr_off] = data;
          wr_off++;
          if (wr_off >= bytes) begin
            wr_off   = 0;
            wr_slice = (wr_slice + 1) % slices;
          end
          in_call = !last;
        end
      end
      OP_FETCH: begin
        rd_slice = (rd_slice + 1) % slices;
        lock_bits[rd_slice] = 1'b1;
      end
      OP_UNLOCK_ID: begin
        if (sid >= slices) res.status = STAT_RANGE;
        else lock_bits[sid] = 1'b0;
      end
      OP_UNLOCK_CUR: begin
        lock_bits[rd_slice] = 1'b0;
      end
      OP_READ: begin
        if (sid >= slices || off >= bytes) res.status = STAT_RANGE;
        else res.read_byte = store_copy[sid * bytes + off];
      end
      default: ;
    endcase
    res.fetched_slice   = SLICE_ID_W'(rd_slice);
    res.write_slice_now = SLICE_ID_W'(wr_slice);
    return res;
  endfunction

  function automatic void check_field(string name, int expected_val, int actual_val);
    if (expected_val != actual_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expected_val, actual_val);
      failures++;
    end
  endfunction

  // Every transfer is sampled at the rising edge; results are taken before new items
  // so that an item can never be matched against its own result in the same cycle.
  always @(posedge clk) begin
    ring_result_t wanted;
    int           delta;
    delta = 0;
    if (rst) begin
      for (int a = 0; a < STORE_DEPTH; a++) store_copy[a] = '0;
      size_reg  = SIZE_AT_RESET;
      count_reg = COUNT_AT_RESET;
      restart_ring();
      pending_results.delete();
      results_owed <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_SLICE_SIZE) begin
          size_reg = cfg.data[SIZE_REG_W-1:0];
          restart_ring();
        end else if (cfg.index == REG_SLICE_COUNT) begin
          count_reg = cfg.data[COUNT_REG_W-1:0];
          restart_ring();
        end
      end
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no expectation waiting");
          failures++;
        end else begin
          wanted = pending_results.pop_front();
          delta--;
          check_field("status", wanted.status, rsp.status);
          check_field("read_byte", wanted.read_byte, rsp.read_byte);
          check_field("fetched_slice", wanted.fetched_slice, rsp.fetched_slice);
          check_field("write_slice_now", wanted.write_slice_now, rsp.write_slice_now);
        end
      end
      if (req.valid && req.ready) begin
        pending_results.push_back(advance_ring(req.operation, req.data_byte,
                                               req.last_of_block, req.slice_id,
                                               req.byte_offset));
        delta++;
      end
      results_owed <= results_owed + delta;
    end
  end

endmodule

/* tb/tb_sliced_ring_buffer_with_locks_unit.sv */
// Top of the sliced ring buffer testbench: clock, reset, stimulus, idling and verdict.
// Depends on srbl_pkg, the channel interfaces, srbl_ring_checker and the block itself.
module tb_sliced_ring_buffer_with_locks_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import srbl_pkg::*;

  logic clk;
  logic rst;
  int   failures;
  int   results_owed;

  // Idling percentages, the current ring shape and the receiver hold-off requests.
  int tx_idle_pct;
  int rx_idle_pct;
  int ring_bytes;
  int ring_slices;
  int hold_requests;
  int holds_done;

  srbl_req_if req_ch();
  srbl_rsp_if rsp_ch();
  srbl_cfg_if cfg_ch();

  sliced_ring_buffer_with_locks_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  srbl_ring_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .cfg          (cfg_ch),
    .failures     (failures),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net: well beyond the clearing pass plus the slowest legal run.
  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: random stalls, or a long counted hold-off when one is requested.
  initial begin
    int hold_cycles;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        rsp_ch.ready <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < 300) begin
          @(posedge clk);
          hold_cycles++;
        end
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Offers one item, with random gaps before it, and returns once it is transferred.
  task automatic send_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data, logic last,
                           logic [SLICE_ID_W-1:0] sid, logic [OFFSET_W-1:0] off);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= op;
    req_ch.data_byte     <= data;
    req_ch.last_of_block <= last;
    req_ch.slice_id      <= sid;
    req_ch.byte_offset   <= off;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Stops offering and waits until every expected result has been transferred.
  task automatic wait_until_settled();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  // Offers one register write and returns once it is transferred, leaving valid high.
  task automatic write_register(reg_index_t idx, int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Reshapes the ring once the block is idle and records the clamped shape for stimulus.
  task automatic set_ring(int size_val, int count_val);
    wait_until_settled();
    write_register(REG_SLICE_SIZE, size_val);
    write_register(REG_SLICE_COUNT, count_val);
    // Both writes go back to back; the channel falls idle after the second.
    cfg_ch.valid <= 1'b0;
    ring_bytes  = (size_val < 1) ? 1 :
                  (size_val > MAX_SLICE_BYTES_DEF) ? MAX_SLICE_BYTES_DEF : size_val;
    ring_slices = (count_val < COUNT_MIN) ? COUNT_MIN :
                  (count_val > MAX_SLICES_DEF) ? MAX_SLICES_DEF : count_val;
  endtask

  // Mostly a slice inside the ring, sometimes any four-bit value.
  function automatic int pick_slice();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, ring_slices - 1);
    return $urandom_range(0, 15);
  endfunction

  // Random traffic: mostly write calls ending in a last byte, with fetches, unlocks and
  // reads in between; a few calls are left open and a few operations are unknown.
  task automatic random_traffic(int n);
    int  sent;
    int  pick;
    int  len;
    int  cap;
    bit  open_call;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        cap       = (2 * ring_bytes + 1 < 24) ? 2 * ring_bytes + 1 : 24;
        len       = $urandom_range(1, cap);
        open_call = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++) begin
          send_item(OP_WRITE, BYTE_W'($urandom), (i == len - 1) && !open_call,
                    SLICE_ID_W'($urandom), OFFSET_W'($urandom));
        end
        sent += len;
      end else begin
        if (pick < 57) begin
          send_item(OP_FETCH, BYTE_W'($urandom), 1'($urandom), SLICE_ID_W'($urandom),
                    OFFSET_W'($urandom));
        end else if (pick < 67) begin
          send_item(OP_UNLOCK_ID, BYTE_W'($urandom), 1'($urandom),
                    SLICE_ID_W'(pick_slice()), OFFSET_W'($urandom));
        end else if (pick < 77) begin
          send_item(OP_UNLOCK_CUR, BYTE_W'($urandom), 1'($urandom), SLICE_ID_W'($urandom),
                    OFFSET_W'($urandom));
        end else if (pick < 96) begin
          send_item(OP_READ, BYTE_W'($urandom), 1'($urandom), SLICE_ID_W'(pick_slice()),
                    OFFSET_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, ring_bytes - 1)
                                                           : $urandom_range(0, 1023)));
        end else begin
          send_item(OP_W'($urandom_range(5, 7)), BYTE_W'($urandom), 1'($urandom),
                    SLICE_ID_W'($urandom), OFFSET_W'($urandom));
        end
        sent++;
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int phase_size  [7];
    int phase_count [7];
    int phase_items [7];
    int phase_tx    [7];
    int phase_rx    [7];
    phase_size           = '{0, 4, 1024, 3, 2047, 5, 1};
    phase_count          = '{0, 16, 3, 31, 16, 5, 16};
    phase_items          = '{250, 300, 150, 300, 100, 350, 300};
    phase_tx             = '{36, 36, 50, 50, 0, 0, 0};
    phase_rx             = '{50, 50, 36, 36, 0, 0, 0};
    rst                  = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.operation     = OP_WRITE;
    req_ch.data_byte     = '0;
    req_ch.last_of_block = 1'b0;
    req_ch.slice_id      = '0;
    req_ch.byte_offset   = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_SLICE_SIZE;
    cfg_ch.data          = '0;
    tx_idle_pct          = 36;
    rx_idle_pct          = 50;
    ring_bytes           = 256;
    ring_slices          = 4;
    hold_requests        = 0;
    holds_done           = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset shape: cleared store, range edges, lock and unlock, unknown operations.
    send_item(OP_READ, 8'h00, 1'b0, 4'd0, 10'd0);
    send_item(OP_READ, 8'hFF, 1'b1, 4'd3, 10'd255);
    send_item(OP_READ, 8'h00, 1'b0, 4'd15, 10'd1023);
    send_item(OP_READ, 8'h00, 1'b0, 4'd0, 10'd256);
    send_item(OP_WRITE, 8'hFF, 1'b0, 4'd15, 10'd1023);
    send_item(OP_WRITE, 8'h00, 1'b1, 4'd0, 10'd0);
    send_item(OP_READ, 8'h00, 1'b0, 4'd0, 10'd0);
    send_item(OP_FETCH, 8'h00, 1'b0, 4'd0, 10'd0);
    send_item(OP_UNLOCK_ID, 8'h00, 1'b0, 4'd15, 10'd0);
    send_item(OP_UNLOCK_CUR, 8'h00, 1'b0, 4'd0, 10'd0);
    send_item(OP_UNLOCK_ID, 8'h00, 1'b0, 4'd1, 10'd0);
    send_item(OP_W'(5), 8'h5A, 1'b1, 4'd2, 10'd7);
    send_item(OP_W'(7), 8'hA5, 1'b0, 4'd9, 10'd512);

    // One-byte slices in a ring of three: the store survives the register writes,
    // refused writes and their retry, the lock check at a new slice and wrap-around.
    set_ring(1, 3);
    send_item(OP_READ, 8'h00, 1'b0, 4'd0, 10'd0);
    send_item(OP_FETCH, 8'h00, 1'b0, 4'd0, 10'd0);
    send_item(OP_WRITE, 8'hA5, 1'b1, 4'd0, 10'd0);
    send_item(OP_WRITE, 8'h5A, 1'b0, 4'd0, 10'd0);
    send_item(OP_WRITE, 8'h5A, 1'b0, 4'd0, 10'd0);
    send_item(OP_UNLOCK_CUR, 8'h00, 1'b0, 4'd0, 10'd0);
    send_item(OP_WRITE, 8'h5A, 1'b0, 4'd0, 10'd0);
    send_item(OP_WRITE, 8'h3C, 1'b0, 4'd0, 10'd0);
    send_item(OP_FETCH, 8'h00, 1'b0, 4'd0, 10'd0);
    send_item(OP_FETCH, 8'h00, 1'b0, 4'd0, 10'd0);
    send_item(OP_WRITE, 8'h11, 1'b1, 4'd0, 10'd0);
    send_item(OP_UNLOCK_ID, 8'h00, 1'b0, 4'd3, 10'd0);

    // Random phases over several ring shapes, the clamped extremes among them.
    for (int p = 0; p < 7; p++) begin
      set_ring(phase_size[p], phase_count[p]);
      tx_idle_pct = phase_tx[p];
      rx_idle_pct = phase_rx[p];
      if (p == 1) begin
        // Long receiver hold-off while items keep coming, so the input backs up.
        hold_requests++;
      end
      if (p == 5) begin
        // The sender pauses halfway until every result is back.
        random_traffic(phase_items[p] / 2);
        wait_until_settled();
        random_traffic(phase_items[p] - phase_items[p] / 2);
      end else begin
        random_traffic(phase_items[p]);
      end
    end

    wait_until_settled();
    if (failures == 0 && results_owed == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
